// ===== rtl/core/rws_pkg.sv =====
// ----------------------------------------------------------------------------
// rws_pkg
// Shared types and constants for the rain-adaptive wiper sweep controller.
// ----------------------------------------------------------------------------
package rws_pkg;

  localparam int ThrWidth   = 12;
  localparam int PulseWidth = 15;
  localparam int StepWidth  = 8;
  localparam int TimeWidth  = 32;
  localparam int DebWidth   = 16;
  localparam int CfgWidth   = 32;
  localparam int IdxWidth   = 3;
  localparam int LevelWidth = 2;

  localparam logic [ThrWidth-1:0]   DryReset    = 12'd3500;
  localparam logic [ThrWidth-1:0]   LightReset  = 12'd2500;
  localparam logic [ThrWidth-1:0]   MediumReset = 12'd1500;
  localparam logic [CfgWidth-1:0]   StepReset   = 32'h7850_280A;
  localparam logic [PulseWidth-1:0] ParkReset   = 15'd833;
  localparam logic [PulseWidth-1:0] EndReset    = 15'd2500;
  localparam logic [DebWidth-1:0]   DebReset    = 16'd200;

  // Item kinds
  localparam logic KindButton = 1'b0;
  localparam logic KindUpdate = 1'b1;

  typedef enum logic [IdxWidth-1:0] {
    REG_DRY_THR    = 3'd0,
    REG_LIGHT_THR  = 3'd1,
    REG_MEDIUM_THR = 3'd2,
    REG_STEP_TABLE = 3'd3,
    REG_PARK_PULSE = 3'd4,
    REG_END_PULSE  = 3'd5,
    REG_DEBOUNCE   = 3'd6
  } reg_idx_t;

  typedef enum logic [LevelWidth-1:0] {
    LEVEL_NONE   = 2'd0,
    LEVEL_LIGHT  = 2'd1,
    LEVEL_MEDIUM = 2'd2,
    LEVEL_HEAVY  = 2'd3
  } level_t;

  typedef struct packed {
    logic [ThrWidth-1:0]   dry_threshold;
    logic [ThrWidth-1:0]   light_threshold;
    logic [ThrWidth-1:0]   medium_threshold;
    logic [CfgWidth-1:0]   step_table;
    logic [PulseWidth-1:0] park_pulse;
    logic [PulseWidth-1:0] end_pulse;
    logic [DebWidth-1:0]   debounce_ms;
  } cfg_t;

  typedef struct packed {
    logic [PulseWidth-1:0] pulse_width;
    logic                  enabled;
    level_t                wet_level;
    logic                  returning;
  } result_t;

endpackage

// ===== rtl/core/rws_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// rws_cfg_regs
// Configuration register file, written by index; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module rws_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [rws_pkg::IdxWidth-1:0]   cfg_index,
  input  logic [rws_pkg::CfgWidth-1:0]   cfg_data,
  output rws_pkg::cfg_t                  cfg
);

  rws_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.dry_threshold    <= rws_pkg::DryReset;
      regs.light_threshold  <= rws_pkg::LightReset;
      regs.medium_threshold <= rws_pkg::MediumReset;
      regs.step_table       <= rws_pkg::StepReset;
      regs.park_pulse       <= rws_pkg::ParkReset;
      regs.end_pulse        <= rws_pkg::EndReset;
      regs.debounce_ms      <= rws_pkg::DebReset;
    end else if (cfg_we) begin
      unique case (rws_pkg::reg_idx_t'(cfg_index))
        rws_pkg::REG_DRY_THR:    regs.dry_threshold    <= cfg_data[rws_pkg::ThrWidth-1:0];
        rws_pkg::REG_LIGHT_THR:  regs.light_threshold  <= cfg_data[rws_pkg::ThrWidth-1:0];
        rws_pkg::REG_MEDIUM_THR: regs.medium_threshold <= cfg_data[rws_pkg::ThrWidth-1:0];
        rws_pkg::REG_STEP_TABLE: regs.step_table       <= cfg_data;
        rws_pkg::REG_PARK_PULSE: regs.park_pulse       <= cfg_data[rws_pkg::PulseWidth-1:0];
        rws_pkg::REG_END_PULSE:  regs.end_pulse        <= cfg_data[rws_pkg::PulseWidth-1:0];
        rws_pkg::REG_DEBOUNCE:   regs.debounce_ms      <= cfg_data[rws_pkg::DebWidth-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

// ===== rtl/core/rws_sweep.sv =====
// ----------------------------------------------------------------------------
// rws_sweep
// Wiper state (debounce, toggle, position, direction) and the combinational
// datapath that turns one item into its state update and result.
// ----------------------------------------------------------------------------
module rws_sweep (
  input  logic                             clk,
  input  logic                             rst,
  input  rws_pkg::cfg_t                    cfg,
  input  logic                             fire,
  input  logic                             kind,
  input  logic [rws_pkg::TimeWidth-1:0]    time_ms,
  input  logic [rws_pkg::ThrWidth-1:0]     rain_reading,
  output rws_pkg::result_t                 res
);

  logic                             wiper_on;
  logic                             toggle_pending;
  logic [rws_pkg::TimeWidth-1:0]    last_press;
  logic [rws_pkg::PulseWidth-1:0]   position;
  logic                             moving_back;

  logic [rws_pkg::TimeWidth-1:0]    press_gap;
  logic                             press_ok;
  logic                             wiper_on_next;
  rws_pkg::level_t                  level;
  logic [rws_pkg::StepWidth-1:0]    step;
  logic [rws_pkg::PulseWidth:0]     fwd_sum;
  logic [rws_pkg::PulseWidth-1:0]   step_ext;
  logic [rws_pkg::PulseWidth-1:0]   bwd_diff;
  logic [rws_pkg::PulseWidth-1:0]   position_next;
  logic                             moving_back_next;
  logic [rws_pkg::PulseWidth-1:0]   pulse_lo;

  // Wrap-around distance since the last accepted press
  assign press_gap = time_ms - last_press;
  assign press_ok  = press_gap > {{(rws_pkg::TimeWidth-rws_pkg::DebWidth){1'b0}},
                                  cfg.debounce_ms};

  assign wiper_on_next = wiper_on ^ toggle_pending;

  always_comb begin
    priority if (rain_reading >= cfg.dry_threshold)    level = rws_pkg::LEVEL_NONE;
    else if (rain_reading >= cfg.light_threshold)      level = rws_pkg::LEVEL_LIGHT;
    else if (rain_reading >= cfg.medium_threshold)     level = rws_pkg::LEVEL_MEDIUM;
    else                                               level = rws_pkg::LEVEL_HEAVY;
  end

  assign step     = cfg.step_table[{level, 3'b000} +: rws_pkg::StepWidth];
  assign step_ext = {{(rws_pkg::PulseWidth-rws_pkg::StepWidth){1'b0}}, step};
  assign fwd_sum  = {1'b0, position} + {1'b0, step_ext};
  // saturates at zero
  assign bwd_diff = (position > step_ext) ? (position - step_ext) : '0;

  always_comb begin
    position_next    = cfg.park_pulse;
    moving_back_next = 1'b0;
    if (wiper_on_next) begin
      if (!moving_back) begin
        if (fwd_sum >= {1'b0, cfg.end_pulse}) begin
          position_next    = cfg.end_pulse;
          moving_back_next = 1'b1;
        end else begin
          position_next    = fwd_sum[rws_pkg::PulseWidth-1:0];
        end
      end else begin
        if (bwd_diff <= cfg.park_pulse) begin
          position_next    = cfg.park_pulse;
          moving_back_next = 1'b0;
        end else begin
          position_next    = bwd_diff;
          moving_back_next = 1'b1;
        end
      end
    end
  end

  // Output clamp: up to park first, then down to end
  assign pulse_lo = (position_next < cfg.park_pulse) ? cfg.park_pulse : position_next;

  always_comb begin
    res.pulse_width = (pulse_lo > cfg.end_pulse) ? cfg.end_pulse : pulse_lo;
    res.enabled     = wiper_on_next;
    res.wet_level   = wiper_on_next ? level : rws_pkg::LEVEL_NONE;
    res.returning   = moving_back_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wiper_on       <= 1'b0;
      toggle_pending <= 1'b0;
      last_press     <= '0;
      position       <= rws_pkg::ParkReset;
      moving_back    <= 1'b0;
    end else if (fire) begin
      if (kind == rws_pkg::KindButton) begin
        if (press_ok) begin
          toggle_pending <= 1'b1;
          last_press     <= time_ms;
        end
      end else begin
        toggle_pending <= 1'b0;
        wiper_on       <= wiper_on_next;
        position       <= position_next;
        moving_back    <= moving_back_next;
      end
    end
  end

endmodule

// ===== rtl/core/rain_adaptive_wiper_sweep.sv =====
// ----------------------------------------------------------------------------
// rain_adaptive_wiper_sweep
// Top level: input register, sweep datapath and result register.
// ----------------------------------------------------------------------------
// Takes one item per clock while item_stall is low. A button item is debounced
// against the last accepted press and gives no result; an update item gives
// exactly one result, held first in the input register, where the debounce,
// toggle, classify and sweep step are all worked out, then in the result
// register. The input register keeps taking items while a result waits in
// the result register; only a waiting update item behind a stalled result
// holds off new items. Configuration takes effect at the next item.
module rain_adaptive_wiper_sweep (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [rws_pkg::IdxWidth-1:0]     cfg_index,
  input  logic [rws_pkg::CfgWidth-1:0]     cfg_data,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  logic                             kind,
  input  logic [rws_pkg::TimeWidth-1:0]    time_ms,
  input  logic [rws_pkg::ThrWidth-1:0]     rain_reading,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [rws_pkg::PulseWidth-1:0]   pulse_width,
  output logic                             enabled,
  output logic [rws_pkg::LevelWidth-1:0]   wet_level,
  output logic                             returning
);

  rws_pkg::cfg_t                    cfg;
  rws_pkg::result_t                 res;

  logic                             hold_valid;
  logic                             hold_kind;
  logic [rws_pkg::TimeWidth-1:0]    hold_time;
  logic [rws_pkg::ThrWidth-1:0]     hold_reading;

  logic                             out_free;
  logic                             fire;
  logic                             load_result;
  logic                             take_item;
  rws_pkg::result_t                 result;

  rws_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rws_sweep u_sweep (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .fire         (fire),
    .kind         (hold_kind),
    .time_ms      (hold_time),
    .rain_reading (hold_reading),
    .res          (res)
  );

  assign out_free    = !result_valid || !result_stall;
  // button items never need the result register
  assign fire        = hold_valid && ((hold_kind == rws_pkg::KindButton) || out_free);
  assign load_result = fire && (hold_kind == rws_pkg::KindUpdate);
  assign item_stall  = hold_valid && !fire;
  assign take_item   = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (take_item) begin
      hold_valid <= 1'b1;
    end else if (fire) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_item) begin
      hold_kind    <= kind;
      hold_time    <= time_ms;
      hold_reading <= rain_reading;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      result <= res;
    end
  end

  assign pulse_width = result.pulse_width;
  assign enabled     = result.enabled;
  assign wet_level   = result.wet_level;
  assign returning   = result.returning;

endmodule

// ===== rtl/core/rws_checker.sv =====
// ----------------------------------------------------------------------------
// rws_checker
// Port-level checks for the wiper sweep controller, bound to the top level.
// ----------------------------------------------------------------------------
module rws_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_stall,
  input  logic                             result_valid,
  input  logic                             result_stall,
  input  logic [rws_pkg::PulseWidth-1:0]   pulse_width,
  input  logic                             enabled,
  input  logic [rws_pkg::LevelWidth-1:0]   wet_level,
  input  logic                             returning
);

  // Pipeline comes out of reset empty and ready
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!result_valid && !item_stall))
    else $error("pipeline not empty after reset");

  // A disabled wiper is parked: no level, no return sweep
  a_disabled_parked: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !enabled) |-> (wet_level == rws_pkg::LEVEL_NONE && !returning))
    else $error("disabled result shows level or direction");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> result_valid)
    else $error("stalled result dropped");

  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=>
      ($stable(pulse_width) && $stable(enabled) && $stable(wet_level) && $stable(returning)))
    else $error("stalled result changed");

endmodule

bind rain_adaptive_wiper_sweep rws_checker u_rws_checker (
  .clk          (clk),
  .rst          (rst),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .pulse_width  (pulse_width),
  .enabled      (enabled),
  .wet_level    (wet_level),
  .returning    (returning)
);
